// ===== hdl/triangle_element_stiffness_defines.svh =====
// Assertion macros used by the checker file of the triangle stiffness block.
`ifndef TRIANGLE_ELEMENT_STIFFNESS_DEFINES_SVH
`define TRIANGLE_ELEMENT_STIFFNESS_DEFINES_SVH

// Checked at every clock edge outside reset.
`define TES_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checked at every clock edge, also while reset is held.
`define TES_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/tes_pkg.sv =====
// Shared types and constants of the triangle element stiffness block.
package tes_pkg;

	localparam int COORD_W   = 24;
	localparam int DIFF_W    = 25;
	localparam int PROD_W    = 50;
	localparam int UV_W      = 52;
	localparam int VP_W      = 68;
	localparam int DET_W     = 51;
	localparam int ADET_W    = 50;
	localparam int ADET_HALF = 25;
	localparam int OMP_W     = 33;
	localparam int DPART_W   = OMP_W + ADET_HALF;
	localparam int SW        = 69;
	localparam int SMAG_W    = 68;
	localparam int DEN_W     = 83;
	localparam int TAG_W     = 16;
	localparam int IDX_W     = 3;
	localparam int VAL_W     = 64;
	localparam int DIGIT_W   = 12;
	localparam int N_DIGITS  = 6;
	localparam int SPAD_W    = DIGIT_W * N_DIGITS;
	localparam int QW        = VAL_W + 1;
	localparam int IN_TDATA_W  = 160;
	localparam int OUT_TDATA_W = 88;

	localparam logic [IDX_W-1:0] LAST_IDX = 3'd5;
	localparam logic [OMP_W-1:0] OMP_ONE  = 33'h1_0000_0000;

	localparam logic [VAL_W-1:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [VAL_W-1:0] VAL_MIN = 64'h8000_0000_0000_0000;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t REG_ELASTIC   = 2'd0;
	localparam cfg_idx_t REG_POISSON   = 2'd1;
	localparam cfg_idx_t REG_THICKNESS = 2'd2;

	localparam logic [23:0] ELASTIC_RST   = 24'd210000;
	localparam logic [14:0] POISSON_RST   = 15'd19661;
	localparam logic [31:0] THICKNESS_RST = 32'd65536;

	// Per-entry control that rides along the pipeline.
	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             last;
		logic             degen;
		logic             sneg;
	} meta_t;

endpackage

// ===== hdl/tes_div.sv =====
// Pipelined restoring divider with round-half-away and 64-bit saturation.
module tes_div import tes_pkg::*; #(
	parameter int NUM_W = 162
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  meta_t            in_meta,
	output logic             out_valid,
	output logic [VAL_W-1:0] out_value,
	output meta_t            out_meta
);

	logic [DEN_W-1:0] rem_s  [0:QW];
	logic [VAL_W-1:0] low_s  [0:QW];
	logic [QW-1:0]    q_s    [0:QW];
	logic [DEN_W-1:0] den_s  [0:QW];
	logic             over_s [0:QW];
	meta_t            meta_s [0:QW];
	logic             vld_s  [0:QW];

	// Entry stage: top part of the numerator seeds the remainder; overflow if it reaches den.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= DEN_W'(num[NUM_W-1:VAL_W]);
			low_s[0]  <= num[VAL_W-1:0];
			q_s[0]    <= '0;
			den_s[0]  <= den;
			over_s[0] <= DEN_W'(num[NUM_W-1:VAL_W]) >= den;
			meta_s[0] <= in_meta;
		end
	end

	// One quotient bit per stage: 64 integer bits, then the rounding bit.
	for (genvar k = 1; k <= QW; k++) begin : g_stage
		logic [DEN_W:0] trial;
		logic           ge;

		assign trial = {rem_s[k-1], low_s[k-1][VAL_W-1]};
		assign ge    = trial >= {1'b0, den_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? DEN_W'(trial - {1'b0, den_s[k-1]}) : DEN_W'(trial);
				low_s[k]  <= low_s[k-1] << 1;
				q_s[k]    <= {q_s[k-1][QW-2:0], ge};
				den_s[k]  <= den_s[k-1];
				over_s[k] <= over_s[k-1];
				meta_s[k] <= meta_s[k-1];
			end
		end
	end

	logic [QW-1:0]    mag;
	logic [VAL_W-1:0] value_d;

	assign mag = {1'b0, q_s[QW][QW-1:1]} + QW'(q_s[QW][0]);

	always_comb begin
		if (meta_s[QW].degen) begin
			value_d = '0;
		end else if (!meta_s[QW].sneg) begin
			if (over_s[QW] || mag[QW-1] || mag[VAL_W-1]) begin
				value_d = VAL_MAX;
			end else begin
				value_d = mag[VAL_W-1:0];
			end
		end else begin
			if (over_s[QW] || mag[QW-1] || (mag[VAL_W-1] && (mag[VAL_W-2:0] != '0))) begin
				value_d = VAL_MIN;
			end else begin
				value_d = -mag[VAL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_value <= value_d;
			out_meta  <= meta_s[QW];
		end
	end

endmodule

// ===== hdl/triangle_element_stiffness.sv =====
// Top level: constant-strain triangle stiffness, plane stress, 36 entries per element.
//
//  channel   | dir | handshake                     | contents
//  ----------+-----+-------------------------------+----------------------------------------
//  s_axis    | in  | tvalid/tready                 | element tag, three corners Q12.12
//  m_axis    | out | tvalid/tready, tlast          | tag, row, col, entry Q48.16, degenerate
//  cfg       | in  | cfg_wr_en, cfg_index          | E, nu, thickness
//
// Each element yields 36 entries, one per cycle while the output is not stalled, all from the
// single entry sequencer feeding one result channel.
// The divider stages make up most of the pipeline depth.
// Reset clears the sequencer, all valid bits and the config registers to their defaults.
// A stalled output freezes the whole pipeline in place; nothing is dropped or repeated.
// The next element is taken while the previous one's entries are still in flight.
module triangle_element_stiffness import tes_pkg::*; #(
	parameter int VALUE_FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  cfg_idx_t               cfg_index,
	input  logic [31:0]            cfg_data,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// tag[15:0], x_first, y_first, x_second, y_second, x_third, y_third (24 bits each)
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// tag_out[15:0], row_index[18:16], col_index[21:19], entry_value[85:22], zeros
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// degenerate
	output logic [0:0]             m_axis_tuser,
	output logic                   m_axis_tlast
);

	// K = E * T * 2^(F-2); numerator width is |S| times K.
	localparam int KW    = 54 + VALUE_FRAC_BITS;
	localparam int NUM_W = SMAG_W + KW;

	// ---------------- configuration ----------------
	logic [23:0] elastic_q;
	logic [14:0] poisson_q;
	logic [31:0] thick_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elastic_q <= ELASTIC_RST;
			poisson_q <= POISSON_RST;
			thick_q   <= THICKNESS_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ELASTIC:   elastic_q <= cfg_data[23:0];
				REG_POISSON:   poisson_q <= cfg_data[14:0];
				REG_THICKNESS: thick_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Config-derived constants, registered from the config registers; om_q is registered again after pp_q.
	logic [55:0]      et_q;
	logic [29:0]      pp_q;
	logic [OMP_W-1:0] om_q;
	logic [KW-1:0]    k_val;

	always_ff @(posedge clk) begin
		et_q <= elastic_q * thick_q;
		pp_q <= poisson_q * poisson_q;
		om_q <= OMP_ONE - OMP_W'(pp_q);
	end

	assign k_val = {et_q, {(VALUE_FRAC_BITS-2){1'b0}}};

	// ---------------- flow control ----------------
	// Global advance: the whole pipe moves unless the output register is held.
	logic adv;
	assign adv = !m_axis_tvalid || m_axis_tready;

	// ---------------- entry sequencer ----------------
	logic                      busy_q;
	logic [IDX_W-1:0]          row_q, col_q;
	logic [TAG_W-1:0]          tag_q;
	logic signed [COORD_W-1:0] xi_q, yi_q, xj_q, yj_q, xk_q, yk_q;
	logic                      seq_last, in_acc;

	assign seq_last      = (row_q == LAST_IDX) && (col_q == LAST_IDX);
	assign s_axis_tready = adv && (!busy_q || seq_last);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			row_q  <= '0;
			col_q  <= '0;
		end else if (adv) begin
			if (in_acc) begin
				busy_q <= 1'b1;
				row_q  <= '0;
				col_q  <= '0;
			end else if (busy_q) begin
				if (seq_last) begin
					busy_q <= 1'b0;
				end else if (col_q == LAST_IDX) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			tag_q <= s_axis_tdata[15:0];
			xi_q  <= s_axis_tdata[39:16];
			yi_q  <= s_axis_tdata[63:40];
			xj_q  <= s_axis_tdata[87:64];
			yj_q  <= s_axis_tdata[111:88];
			xk_q  <= s_axis_tdata[135:112];
			yk_q  <= s_axis_tdata[159:136];
		end
	end

	// Coordinate differences that make up B (unscaled).
	logic signed [DIFF_W-1:0] a0, a1, a2, b0, b1, b2;
	assign a0 = DIFF_W'(yj_q) - DIFF_W'(yk_q);
	assign a1 = DIFF_W'(yk_q) - DIFF_W'(yi_q);
	assign a2 = DIFF_W'(yi_q) - DIFF_W'(yj_q);
	assign b0 = DIFF_W'(xk_q) - DIFF_W'(xj_q);
	assign b1 = DIFF_W'(xi_q) - DIFF_W'(xk_q);
	assign b2 = DIFF_W'(xj_q) - DIFF_W'(xi_q);

	function automatic logic signed [DIFF_W-1:0] pick3(
		input logic [1:0]               n,
		input logic signed [DIFF_W-1:0] v0,
		input logic signed [DIFF_W-1:0] v1,
		input logic signed [DIFF_W-1:0] v2
	);
		case (n)
			2'd0:    return v0;
			2'd1:    return v1;
			default: return v2;
		endcase
	endfunction

	// Column of B for a dof index: even -> (a, 0, b), odd -> (0, b, a).
	logic signed [DIFF_W-1:0] ra, rb, ca, cb;
	logic signed [DIFF_W-1:0] g0_d, g1_d, g2_d, h0_d, h1_d, h2_d;

	assign ra   = pick3(row_q[2:1], a0, a1, a2);
	assign rb   = pick3(row_q[2:1], b0, b1, b2);
	assign ca   = pick3(col_q[2:1], a0, a1, a2);
	assign cb   = pick3(col_q[2:1], b0, b1, b2);
	assign g0_d = row_q[0] ? '0 : ra;
	assign g1_d = row_q[0] ? rb : '0;
	assign g2_d = row_q[0] ? ra : rb;
	assign h0_d = col_q[0] ? '0 : ca;
	assign h1_d = col_q[0] ? cb : '0;
	assign h2_d = col_q[0] ? ca : cb;

	// ---------------- S1: B columns ----------------
	logic                     vld_s1;
	logic signed [DIFF_W-1:0] g0_s1, g1_s1, g2_s1, h0_s1, h1_s1, h2_s1;
	logic signed [DIFF_W-1:0] a1_s1, a2_s1, b1_s1, b2_s1;
	meta_t                    meta_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			g0_s1 <= g0_d;
			g1_s1 <= g1_d;
			g2_s1 <= g2_d;
			h0_s1 <= h0_d;
			h1_s1 <= h1_d;
			h2_s1 <= h2_d;
			a1_s1 <= a1;
			a2_s1 <= a2;
			b1_s1 <= b1;
			b2_s1 <= b2;
			meta_s1.tag   <= tag_q;
			meta_s1.row   <= row_q;
			meta_s1.col   <= col_q;
			meta_s1.last  <= seq_last;
			meta_s1.degen <= 1'b0;
			meta_s1.sneg  <= 1'b0;
		end
	end

	// ---------------- S2: products ----------------
	logic                     vld_s2;
	logic signed [PROD_W-1:0] gg0_s2, gg1_s2, gg2_s2, x01_s2, x10_s2, dp1_s2, dp2_s2;
	meta_t                    meta_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gg0_s2  <= g0_s1 * h0_s1;
			gg1_s2  <= g1_s1 * h1_s1;
			gg2_s2  <= g2_s1 * h2_s1;
			x01_s2  <= g0_s1 * h1_s1;
			x10_s2  <= g1_s1 * h0_s1;
			dp1_s2  <= b2_s1 * a1_s1;
			dp2_s2  <= b1_s1 * a2_s1;
			meta_s2 <= meta_s1;
		end
	end

	// ---------------- S3: u, v, twice-area ----------------
	logic                    vld_s3;
	logic signed [UV_W-1:0]  u_s3, v_s3;
	logic signed [DET_W-1:0] det_s3;
	meta_t                   meta_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s3    <= (UV_W'(gg0_s2) <<< 1) + (UV_W'(gg1_s2) <<< 1) + UV_W'(gg2_s2);
			v_s3    <= (UV_W'(x01_s2) <<< 1) + (UV_W'(x10_s2) <<< 1) - UV_W'(gg2_s2);
			det_s3  <= DET_W'(dp1_s2) - DET_W'(dp2_s2);
			meta_s3 <= meta_s2;
		end
	end

	// ---------------- S4: v*nu, |det| ----------------
	logic                    vld_s4;
	logic signed [VP_W-1:0]  vp_s4;
	logic signed [UV_W-1:0]  u_s4;
	logic [ADET_W-1:0]       adet_s4;
	logic signed [DET_W-1:0] det_abs;
	meta_t                   meta_d4;
	meta_t                   meta_s4;

	assign det_abs = det_s3[DET_W-1] ? -det_s3 : det_s3;

	always_comb begin
		meta_d4       = meta_s3;
		meta_d4.degen = (det_s3 == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vp_s4   <= v_s3 * $signed({1'b0, poisson_q});
			u_s4    <= u_s3;
			adet_s4 <= det_abs[ADET_W-1:0];
			meta_s4 <= meta_d4;
		end
	end

	// ---------------- S5: S and denominator halves ----------------
	logic                  vld_s5;
	logic signed [SW-1:0]  s_s5;
	logic [DPART_W-1:0]    dlo_s5, dhi_s5;
	meta_t                 meta_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s5    <= (SW'(u_s4) <<< 16) + SW'(vp_s4);
			dlo_s5  <= om_q * adet_s4[ADET_HALF-1:0];
			dhi_s5  <= om_q * adet_s4[ADET_W-1:ADET_HALF];
			meta_s5 <= meta_s4;
		end
	end

	// ---------------- S6: |S|, den; heads the multiplier stages ----------------
	logic signed [SW-1:0] s_abs;
	meta_t                meta_d6;
	logic [SPAD_W-1:0]    smag_s [0:N_DIGITS-1];
	logic [NUM_W-1:0]     acc_s  [1:N_DIGITS];
	logic [DEN_W-1:0]     den_s  [0:N_DIGITS];
	meta_t                meta_m [0:N_DIGITS];
	logic                 vld_m  [0:N_DIGITS];

	assign s_abs = s_s5[SW-1] ? -s_s5 : s_s5;

	always_comb begin
		meta_d6      = meta_s5;
		meta_d6.sneg = s_s5[SW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_m[0] <= 1'b0;
		end else if (adv) begin
			vld_m[0] <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			smag_s[0] <= SPAD_W'(s_abs[SMAG_W-1:0]);
			den_s[0]  <= DEN_W'(dlo_s5) + (DEN_W'(dhi_s5) << ADET_HALF);
			meta_m[0] <= meta_d6;
		end
	end

	// |S| * K, one 12-bit digit of |S| per stage.
	for (genvar k = 1; k <= N_DIGITS; k++) begin : g_mul
		logic [KW+DIGIT_W-1:0] prod;
		logic [NUM_W-1:0]      acc_in;

		assign prod = k_val * smag_s[k-1][DIGIT_W-1:0];

		if (k == 1) begin : g_first
			assign acc_in = '0;
		end else begin : g_next
			assign acc_in = acc_s[k-1];
		end

		if (k < N_DIGITS) begin : g_shift
			always_ff @(posedge clk) begin
				if (adv) begin
					smag_s[k] <= smag_s[k-1] >> DIGIT_W;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_m[k] <= 1'b0;
			end else if (adv) begin
				vld_m[k] <= vld_m[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				acc_s[k]  <= acc_in + (NUM_W'(prod) << (DIGIT_W * (k - 1)));
				den_s[k]  <= den_s[k-1];
				meta_m[k] <= meta_m[k-1];
			end
		end
	end

	// ---------------- divide, round, saturate; output register ----------------
	logic [VAL_W-1:0] value_o;
	meta_t            meta_o;

	tes_div #(
		.NUM_W(NUM_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_m[N_DIGITS]),
		.num       (acc_s[N_DIGITS]),
		.den       (den_s[N_DIGITS]),
		.in_meta   (meta_m[N_DIGITS]),
		.out_valid (m_axis_tvalid),
		.out_value (value_o),
		.out_meta  (meta_o)
	);

	assign m_axis_tdata    = {2'b00, value_o, meta_o.col, meta_o.row, meta_o.tag};
	assign m_axis_tuser[0] = meta_o.degen;
	assign m_axis_tlast    = meta_o.last;

endmodule

// ===== hdl/tes_checker.sv =====
// Port-level checks of the triangle stiffness block, bound to the top level.
`include "triangle_element_stiffness_defines.svh"

module tes_checker import tes_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   cfg_wr_en,
	input cfg_idx_t               cfg_index,
	input logic [31:0]            cfg_data,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [0:0]             m_axis_tuser,
	input logic                   m_axis_tlast
);

	`TES_ASSERT_RST(a_no_valid_in_reset, !arst_n |-> !m_axis_tvalid, "output valid during reset")

	`TES_ASSERT(a_hold_stalled, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

	`TES_ASSERT(a_last_is_corner, m_axis_tvalid |-> (m_axis_tlast == ((m_axis_tdata[18:16] == LAST_IDX) && (m_axis_tdata[21:19] == LAST_IDX))), "tlast not on final entry")

	`TES_ASSERT(a_index_range, m_axis_tvalid |-> (m_axis_tdata[18:16] <= LAST_IDX) && (m_axis_tdata[21:19] <= LAST_IDX), "row or column out of range")

	`TES_ASSERT(a_degen_zero, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[85:22] == '0, "degenerate entry not zero")

endmodule

bind triangle_element_stiffness tes_checker u_tes_checker (.*);
